// File: rtl/core/sbld_pkg.sv
// sbld_pkg: shared types and constants of the STX / BCD length / LRC deframer
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package sbld_pkg;

   localparam int ByteW   = 8;
   localparam int CountW  = 15;
   localparam int StatusW = 3;

   localparam logic [ByteW-1:0] STX_BYTE = 8'h02;
   localparam logic [ByteW-1:0] ETX_BYTE = 8'h03;

   localparam logic [CountW-1:0] MAX_PAYLOAD_RESET = 15'd1000;

   typedef enum logic [StatusW-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_START   = 3'd1,
      ST_END_IDLE    = 3'd2,
      ST_END_LENGTH  = 3'd3,
      ST_END_PAYLOAD = 3'd4,
      ST_END_TRAILER = 3'd5,
      ST_BAD_ETX     = 3'd6,
      ST_LRC_ERROR   = 3'd7
   } status_type;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_LEN1 = 6'b000010,
      PH_LEN2 = 6'b000100,
      PH_DATA = 6'b001000,
      PH_ETX  = 6'b010000,
      PH_LRC  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [ByteW-1:0] byte_in;
      logic             stream_end;
   } req_item_type;

   typedef struct packed {
      logic [ByteW-1:0]   out_byte;
      logic               byte_valid;
      logic               frame_done;
      logic [StatusW-1:0] status;
      logic [CountW-1:0]  delivered_count;
   } rsp_item_type;

   // bcd-style weighting, each nibble at face value
   function automatic logic [CountW-1:0] frame_length(input logic [ByteW-1:0] hi,
                                                      input logic [ByteW-1:0] lo);
      logic [CountW-1:0] d3, d2, d1, d0;
      d3 = {11'd0, hi[7:4]} * 15'd1000;
      d2 = {11'd0, hi[3:0]} * 15'd100;
      d1 = {11'd0, lo[7:4]} * 15'd10;
      d0 = {11'd0, lo[3:0]};
      return d3 + d2 + d1 + d0;
   endfunction

endpackage

// File: rtl/core/sbld_if.sv
// sbld_if: valid/ready channel interfaces of the deframer (request, response, csr)
// depends on sbld_pkg for the payload widths
`timescale 1ns / 1ps

interface sbld_req_if;
   import sbld_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] byte_in;
   logic             stream_end;
   modport source (output valid, output byte_in, output stream_end, input ready);
   modport sink (input valid, input byte_in, input stream_end, output ready);
endinterface

interface sbld_rsp_if;
   import sbld_pkg::*;
   logic               valid;
   logic               ready;
   logic [ByteW-1:0]   out_byte;
   logic               byte_valid;
   logic               frame_done;
   logic [StatusW-1:0] status;
   logic [CountW-1:0]  delivered_count;
   modport source (output valid, output out_byte, output byte_valid, output frame_done,
                   output status, output delivered_count, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input frame_done,
                 input status, input delivered_count, output ready);
endinterface

interface sbld_csr_if;
   import sbld_pkg::*;
   logic              valid;
   logic              ready;
   logic [CountW-1:0] max_payload;
   modport source (output valid, output max_payload, input ready);
   modport sink (input valid, input max_payload, output ready);
endinterface

// File: rtl/core/sbld_in_stage.sv
// sbld_in_stage: input register for request items
// depends on sbld_pkg and sbld_req_if
`timescale 1ns / 1ps

module sbld_in_stage
   import sbld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sbld_req_if.sink      req_ch,
   input  logic          take,
   output logic          item_valid,
   output req_item_type  item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.byte_in    <= req_ch.byte_in;
         item_ff.stream_end <= req_ch.stream_end;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/sbld_frame_core.sv
// sbld_frame_core: frame state machine, length decode, lrc and payload counting
// depends on sbld_pkg and sbld_csr_if
`timescale 1ns / 1ps

module sbld_frame_core
   import sbld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sbld_csr_if.sink      csr_ch,
   input  logic          item_valid,
   input  req_item_type  item,
   output logic          take,
   output logic          out_load,
   input  logic          out_free,
   output rsp_item_type  result
);

   phase_type         phase_ff, phase_in;
   logic [CountW-1:0] decl_len_ff, decl_len_in;
   logic [CountW-1:0] seen_ff, seen_in;
   logic [ByteW-1:0]  lrc_ff, lrc_in;
   logic [ByteW-1:0]  first_ff, first_in;
   logic [CountW-1:0] max_ff;

   logic [ByteW-1:0]  b;
   logic              at_end;
   logic              has_result;
   logic [CountW-1:0] seen_inc;
   logic [CountW-1:0] delivered;
   logic [CountW-1:0] new_len;

   assign b         = item.byte_in;
   assign at_end    = item.stream_end;
   assign seen_inc  = seen_ff + 15'd1;
   assign delivered = (seen_ff < max_ff) ? seen_ff : max_ff;
   assign new_len   = frame_length(first_ff, b);

   assign csr_ch.ready = 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      decl_len_in = decl_len_ff;
      seen_in     = seen_ff;
      lrc_in      = lrc_ff;
      first_in    = first_ff;
      has_result  = 1'b0;
      result      = '0;
      unique case (phase_ff)
         PH_LEN1: begin
            if (at_end) begin
               has_result    = 1'b1;
               result.status = ST_END_LENGTH;
            end else begin
               first_in = b;
               lrc_in   = b;
               phase_in = PH_LEN2;
            end
         end
         PH_LEN2: begin
            if (at_end) begin
               has_result    = 1'b1;
               result.status = ST_END_LENGTH;
            end else begin
               decl_len_in = new_len;
               lrc_in      = lrc_ff ^ b;
               seen_in     = '0;
               phase_in    = (new_len == '0) ? PH_ETX : PH_DATA;
            end
         end
         PH_DATA: begin
            if (at_end) begin
               has_result             = 1'b1;
               result.status          = ST_END_PAYLOAD;
               result.delivered_count = delivered;
            end else begin
               lrc_in  = lrc_ff ^ b;
               seen_in = seen_inc;
               if (seen_inc >= decl_len_ff) begin
                  phase_in = PH_ETX;
               end
               // bytes past max_payload still count and enter the lrc
               if (seen_inc <= max_ff) begin
                  has_result        = 1'b1;
                  result.out_byte   = b;
                  result.byte_valid = 1'b1;
               end
            end
         end
         PH_ETX: begin
            if (at_end) begin
               has_result             = 1'b1;
               result.status          = ST_END_TRAILER;
               result.delivered_count = delivered;
            end else if (b != ETX_BYTE) begin
               has_result             = 1'b1;
               result.status          = ST_BAD_ETX;
               result.delivered_count = delivered;
            end else begin
               lrc_in   = lrc_ff ^ ETX_BYTE;
               phase_in = PH_LRC;
            end
         end
         PH_LRC: begin
            has_result             = 1'b1;
            result.delivered_count = delivered;
            if (at_end) begin
               result.status = ST_END_TRAILER;
            end else if (b == lrc_ff) begin
               result.status = ST_OK;
            end else begin
               result.status = ST_LRC_ERROR;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (at_end) begin
               has_result    = 1'b1;
               result.status = ST_END_IDLE;
            end else if (b != STX_BYTE) begin
               has_result    = 1'b1;
               result.status = ST_BAD_START;
            end else begin
               decl_len_in = '0;
               seen_in     = '0;
               lrc_in      = '0;
               first_in    = '0;
               phase_in    = PH_LEN1;
            end
         end
      endcase
      // every final status sends the machine back to idle
      if (has_result && !result.byte_valid) begin
         result.frame_done = 1'b1;
         phase_in          = PH_IDLE;
      end
   end

   // an item without a result never waits on the output register
   assign take     = item_valid && (!has_result || out_free);
   assign out_load = take && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         decl_len_ff <= '0;
         seen_ff     <= '0;
         lrc_ff      <= '0;
         first_ff    <= '0;
         max_ff      <= MAX_PAYLOAD_RESET;
      end else begin
         if (take) begin
            phase_ff    <= phase_in;
            decl_len_ff <= decl_len_in;
            seen_ff     <= seen_in;
            lrc_ff      <= lrc_in;
            first_ff    <= first_in;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            max_ff <= csr_ch.max_payload;
         end
      end
   end

endmodule

// File: rtl/core/sbld_out_stage.sv
// sbld_out_stage: result register driving the response channel
// depends on sbld_pkg and sbld_rsp_if
`timescale 1ns / 1ps

module sbld_out_stage
   import sbld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          out_load,
   output logic          out_free,
   input  rsp_item_type  result,
   sbld_rsp_if.source    rsp_ch
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         item_ff <= result;
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.out_byte        = item_ff.out_byte;
   assign rsp_ch.byte_valid      = item_ff.byte_valid;
   assign rsp_ch.frame_done      = item_ff.frame_done;
   assign rsp_ch.status          = item_ff.status;
   assign rsp_ch.delivered_count = item_ff.delivered_count;

endmodule

// File: rtl/core/stx_bcd_lrc_deframer.sv
// stx_bcd_lrc_deframer: top level of the STX / BCD length / LRC frame receiver
// depends on sbld_pkg, sbld_if, sbld_in_stage, sbld_frame_core, sbld_out_stage
//
// usage:
//   req_ch  one received byte per request, or stream_end for a closed link
//   rsp_ch  a delivered payload byte (byte_valid) or a final frame status
//           (frame_done, status, delivered_count); zero or one per request
//   csr_ch  writes max_payload; always ready, write only while idle
// a request is registered at its accepting edge, decoded by the frame state
// machine and loaded into the output register once that register is free;
// the response is driven from the output register; throughput is one request
// per cycle unless a result waits on a full output register; the update of the
// frame machine (length decode, lrc xor, byte count compare) sets that pace
// while the response is stalled, requests with no result keep flowing and
// the input register holds one more request; req_ch.ready drops only when a
// request with a result is blocked behind a full output register
// synchronous reset empties both registers, returns to waiting for STX and
// sets max_payload to 1000
`timescale 1ns / 1ps

module stx_bcd_lrc_deframer
   import sbld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sbld_req_if.sink   req_ch,
   sbld_rsp_if.source rsp_ch,
   sbld_csr_if.sink   csr_ch
);

   logic         item_valid;
   req_item_type item;
   logic         take;
   logic         out_load;
   logic         out_free;
   rsp_item_type result;

   sbld_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   sbld_frame_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .out_load   (out_load),
      .out_free   (out_free),
      .result     (result)
   );

   sbld_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .out_load (out_load),
      .out_free (out_free),
      .result   (result),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: tb/stx_bcd_lrc_deframer_tb.sv
// stx_bcd_lrc_deframer_tb: self-checking bench for the stx / bcd length / lrc deframer
// depends on sbld_pkg, sbld_if and the rtl; random frames against a behavioral frame predictor
`timescale 1ns / 1ps

module stx_bcd_lrc_deframer_tb;
   import sbld_pkg::*;

   typedef enum int {
      FR_CLEAN,
      FR_BAD_LRC,
      FR_BAD_ETX,
      FR_END_DATA,
      FR_END_ETX,
      FR_END_LRC,
      FR_END_LEN
   } flaw_type;

   logic clock;
   logic reset;

   sbld_req_if req_ch ();
   sbld_rsp_if rsp_ch ();
   sbld_csr_if csr_ch ();

   stx_bcd_lrc_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // request stream waiting to be driven, and deframer output still owed
   req_item_type rx_stream [$];
   rsp_item_type deframed_q [$];
   int           rx_queued;
   int           rx_taken;
   int           mismatches;
   int           gap_left;
   int           stall_left;
   bit           quiet;
   req_item_type taken;
   rsp_item_type got;
   rsp_item_type want;

   // predictor copy of the frame receiver
   phase_type         rx_phase;
   logic [CountW-1:0] rx_limit;
   logic [CountW-1:0] rx_len;
   logic [CountW-1:0] rx_seen;
   logic [ByteW-1:0]  rx_lrc;
   logic [ByteW-1:0]  rx_hi;

   function automatic int unsigned bcd_weight(input logic [7:0] hi, input logic [7:0] lo);
      return hi[7:4] * 1000 + hi[3:0] * 100 + lo[7:4] * 10 + lo[3:0];
   endfunction

   function automatic logic [CountW-1:0] delivered_so_far();
      return (rx_seen < rx_limit) ? rx_seen : rx_limit;
   endfunction

   function automatic void close_frame(input status_type st, input logic [CountW-1:0] cnt);
      rsp_item_type r;
      r = '0;
      r.frame_done = 1'b1;
      r.status = st;
      r.delivered_count = cnt;
      deframed_q.push_back(r);
      rx_phase = PH_IDLE;
   endfunction

   function automatic void deframe_byte(input req_item_type it);
      logic [ByteW-1:0] b;
      int unsigned      len;
      rsp_item_type     r;
      b = it.byte_in;
      case (rx_phase)
         PH_LEN1: begin
            if (it.stream_end) close_frame(ST_END_LENGTH, '0);
            else begin
               rx_hi = b;
               rx_lrc = b;
               rx_phase = PH_LEN2;
            end
         end
         PH_LEN2: begin
            if (it.stream_end) close_frame(ST_END_LENGTH, '0);
            else begin
               len = bcd_weight(rx_hi, b);
               rx_len = len[CountW-1:0];
               rx_lrc ^= b;
               rx_seen = '0;
               rx_phase = (rx_len == 0) ? PH_ETX : PH_DATA;
            end
         end
         PH_DATA: begin
            if (it.stream_end) close_frame(ST_END_PAYLOAD, delivered_so_far());
            else begin
               rx_lrc ^= b;
               rx_seen = rx_seen + 1'b1;
               if (rx_seen >= rx_len) rx_phase = PH_ETX;
               // bytes past the limit still count and still enter the lrc
               if (rx_seen <= rx_limit) begin
                  r = '0;
                  r.out_byte = b;
                  r.byte_valid = 1'b1;
                  deframed_q.push_back(r);
               end
            end
         end
         PH_ETX: begin
            if (it.stream_end) close_frame(ST_END_TRAILER, delivered_so_far());
            else if (b != ETX_BYTE) close_frame(ST_BAD_ETX, delivered_so_far());
            else begin
               rx_lrc ^= ETX_BYTE;
               rx_phase = PH_LRC;
            end
         end
         PH_LRC: begin
            if (it.stream_end) close_frame(ST_END_TRAILER, delivered_so_far());
            else close_frame((b == rx_lrc) ? ST_OK : ST_LRC_ERROR, delivered_so_far());
         end
         default: begin
            rx_phase = PH_IDLE;
            if (it.stream_end) close_frame(ST_END_IDLE, '0);
            else if (b != STX_BYTE) close_frame(ST_BAD_START, '0);
            else begin
               rx_len = '0;
               rx_seen = '0;
               rx_lrc = '0;
               rx_hi = '0;
               rx_phase = PH_LEN1;
            end
         end
      endcase
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic string show(input rsp_item_type r);
      return $sformatf("byte %02h byte_valid %0b frame_done %0b status %0d count %0d",
                       r.out_byte, r.byte_valid, r.frame_done, r.status, r.delivered_count);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      req_item_type it;
      it.byte_in = b;
      it.stream_end = 1'b0;
      rx_stream.push_back(it);
      rx_queued++;
   endtask

   // the byte lane carries junk on a stream end, the block must ignore it
   task automatic push_end();
      req_item_type it;
      it.byte_in = 8'($urandom);
      it.stream_end = 1'b1;
      rx_stream.push_back(it);
      rx_queued++;
   endtask

   task automatic queue_frame(input logic [7:0] hi, input logic [7:0] lo,
                              input flaw_type flaw, input int cut);
      logic [7:0]  lrc;
      logic [7:0]  b;
      int unsigned n;
      push_byte(STX_BYTE);
      if (flaw == FR_END_LEN) begin
         if ($urandom_range(0, 1)) push_byte(hi);
         push_end();
         return;
      end
      push_byte(hi);
      push_byte(lo);
      lrc = hi ^ lo;
      n = bcd_weight(hi, lo);
      if (flaw == FR_END_DATA && cut < n) n = cut;
      repeat (n) begin
         b = 8'($urandom);
         lrc ^= b;
         push_byte(b);
      end
      if (flaw == FR_END_DATA || flaw == FR_END_ETX) begin
         push_end();
         return;
      end
      if (flaw == FR_BAD_ETX) begin
         b = 8'($urandom);
         if (b == ETX_BYTE) b ^= 8'h80;
         push_byte(b);
         return;
      end
      push_byte(ETX_BYTE);
      lrc ^= ETX_BYTE;
      if (flaw == FR_END_LRC) push_end();
      else if (flaw == FR_BAD_LRC) push_byte(lrc ^ 8'($urandom_range(1, 255)));
      else push_byte(lrc);
   endtask

   task automatic random_frame();
      logic [7:0] hi;
      logic [7:0] lo;
      flaw_type   flaw;
      int         s;
      s = $urandom_range(0, 99);
      flaw = ($urandom_range(0, 99) < 65) ? FR_CLEAN : flaw_type'($urandom_range(1, 6));
      hi = 8'h00;
      lo = {4'($urandom_range(0, 2)), 4'($urandom)};
      if (s >= 70 && s < 88) lo = 8'($urandom);
      else if (s >= 88 && s < 95) begin
         hi = 8'h01;
         lo = 8'($urandom);
      end else if (s >= 95) begin
         // declared lengths over 60 are cut short by a stream end
         hi = 8'($urandom);
         lo = 8'($urandom);
         if (bcd_weight(hi, lo) > 60) flaw = FR_END_DATA;
      end
      queue_frame(hi, lo, flaw, $urandom_range(0, 40));
   endtask

   task automatic drain();
      while (rx_taken != rx_queued || deframed_q.size() != 0) @(posedge clock);
      // requests with no result may still be in the pipeline
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CountW-1:0] v);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.max_payload <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      rx_limit = v;
   endtask

   initial begin
      reset = 1'b1;
      clock = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.byte_in = '0;
      req_ch.stream_end = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.max_payload = '0;
      forever #5 clock = ~clock;
   end

   // request driver: predicts each request as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.byte_in <= '0;
         req_ch.stream_end <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.byte_in = req_ch.byte_in;
            taken.stream_end = req_ch.stream_end;
            deframe_byte(taken);
            rx_taken++;
            gap_left = idle_span();
            if ($urandom_range(0, 149) == 0) quiet = !quiet;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
               taken = rx_stream.pop_front();
               req_ch.byte_in <= taken.byte_in;
               req_ch.stream_end <= taken.stream_end;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_byte = rsp_ch.out_byte;
            got.byte_valid = rsp_ch.byte_valid;
            got.frame_done = rsp_ch.frame_done;
            got.status = rsp_ch.status;
            got.delivered_count = rsp_ch.delivered_count;
            if (deframed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 20)
                  $display("%0t: unexpected result: expected none, actual %s", $time, show(got));
            end else begin
               want = deframed_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 20)
                     $display("%0t: result mismatch: expected %s, actual %s",
                              $time, show(want), show(got));
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_span();
         end
      end
   end

   initial begin
      logic [CountW-1:0] plan;
      int                goal;
      rx_queued = 0;
      rx_taken = 0;
      mismatches = 0;
      gap_left = 0;
      stall_left = 0;
      quiet = 1'b0;
      rx_phase = PH_IDLE;
      rx_limit = MAX_PAYLOAD_RESET;
      rx_len = '0;
      rx_seen = '0;
      rx_lrc = '0;
      rx_hi = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: idle errors, short length field, zero length, long header, trailer errors
      push_end();
      push_byte(8'hff);
      push_byte(STX_BYTE);
      push_end();
      queue_frame(8'h00, 8'h00, FR_CLEAN, 0);
      queue_frame(8'hff, 8'hff, FR_END_DATA, 1);
      queue_frame(8'h00, 8'h01, FR_BAD_ETX, 0);
      queue_frame(8'h00, 8'h01, FR_BAD_LRC, 0);
      drain();

      for (int k = 0; k < 6; k++) begin
         case (k)
            0: plan = 15'd0;
            1: plan = 15'd16665;
            2: plan = 15'd1;
            3: plan = 15'd7;
            4: plan = 15'd40;
            default: plan = MAX_PAYLOAD_RESET;
         endcase
         write_limit(plan);
         goal = rx_queued + 320;
         while (rx_queued < goal) begin
            case ($urandom_range(0, 99)) inside
               [0:7]: push_byte(8'($urandom));
               [8:10]: push_end();
               default: random_frame();
            endcase
         end
         // leave a frame open so the next limit applies to it in mid-frame
         if ($urandom_range(0, 1)) begin
            push_byte(STX_BYTE);
            push_byte(8'h00);
            push_byte(8'h15);
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && deframed_q.size() == 0)
         $display("stx_bcd_lrc_deframer verification clean");
      else
         $display("stx_bcd_lrc_deframer verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("stx_bcd_lrc_deframer verification failed");
      $finish;
   end

endmodule
